// ===== design/lz11_pkg.sv =====
// Shared types and constants for the LZ11 decompressor.
package lz11_pkg;

    localparam int unsigned WindowDepth = 4096;
    localparam int unsigned WinAw = $clog2(WindowDepth);

    typedef enum logic [3:0] {
        PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_FLAG,
        PH_TOKEN, PH_EXT1, PH_EXT2, PH_EXT3, PH_COPY
    } t_phase;

    typedef enum logic [1:0] {
        ST_BYTE = 2'd0, ST_BAD_TYPE = 2'd1, ST_REFUSED = 2'd2, ST_TOO_FAR = 2'd3
    } t_status;

    localparam logic [7:0] TypeByte = 8'h11;
    localparam logic [16:0] LongBias = 17'h111;
    localparam logic [16:0] MidBias = 17'h11;

    // Work handed from front to back
    typedef struct packed {
        logic        is_err;   // emit an error word
        t_status     status;
        logic        is_lit;   // write literal into history
        logic [7:0]  data;
        logic        is_copy;  // read history at addr
        logic [WinAw-1:0] addr;
        logic [WinAw-1:0] waddr;  // history slot for the output byte
        logic        last;
    } t_cmd;

endpackage

// ===== design/lz11_if.sv =====
// Valid/ready channel interfaces for input and output words.
interface lz11_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] compressed_byte;
    modport source (output valid, action, compressed_byte, input ready);
    modport sink (input valid, action, compressed_byte, output ready);
endinterface

interface lz11_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_last;
    logic [1:0] status;
    modport source (output valid, out_byte, is_last, status, input ready);
    modport sink (input valid, out_byte, is_last, status, output ready);
endinterface

// ===== design/lz11_decompressor_top.sv =====
// LZ11 decompressor top level: parser front, history back end.
// Path: a literal or error word is registered in stage 1, then in the output queue.
// A copy byte is read from history as its request enters stage 1; one history read per word.
// Throughput: one input word per cycle while stage 1 can advance; output back-pressure stalls it.
// Reset: synchronous active-low; control state clears, history stays undefined.
module lz11_decompressor_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lz11_in_if.sink       i_in,
    lz11_out_if.source    o_out
);
    logic           cmd_valid, cmd_ready;
    lz11_pkg::t_cmd cmd;

    lz11_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_action    (i_in.action),
        .i_byte      (i_in.compressed_byte),
        .i_cmd_ready (cmd_ready),
        .o_ready     (i_in.ready),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    lz11_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_valid     (o_out.valid),
        .o_byte      (o_out.out_byte),
        .o_last      (o_out.is_last),
        .o_status    (o_out.status),
        .i_ready     (o_out.ready)
    );
endmodule

// ===== design/lz11_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module lz11_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end
    assign o_rdata = r_rdata;
endmodule

// ===== design/lz11_front.sv =====
// Stream parser: header, flags, tokens and copy bookkeeping.
module lz11_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_action,
    input  logic [7:0]      i_byte,
    input  logic            i_cmd_ready,
    output logic            o_ready,
    output logic            o_cmd_valid,
    output lz11_pkg::t_cmd  o_cmd
);
    localparam int unsigned Aw = lz11_pkg::WinAw;
    localparam logic [Aw:0] WinFull = {1'b1, {Aw{1'b0}}};

    lz11_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_flag, n_flag;
    logic [3:0]  r_fpos, n_fpos;
    logic [7:0]  r_t1, n_t1, r_t2, n_t2, r_t3, n_t3;
    logic [16:0] r_rem, n_rem;
    logic [Aw:0] r_dist, n_dist;
    logic [23:0] r_left, n_left;
    logic [Aw:0] r_written, n_written;
    logic [Aw-1:0] r_wp, n_wp;
    logic        fire;
    logic [16:0] tlen;
    logic [Aw:0] tdist;
    logic        tdone;
    logic [23:0] left_dec;

    assign o_ready = i_cmd_ready;
    assign fire    = i_valid && i_cmd_ready;
    assign left_dec = (r_left != 24'd0) ? r_left - 24'd1 : r_left;

    // Token decode for the byte completing a match
    always_comb begin
        tlen  = '0;
        tdist = '0;
        tdone = 1'b0;
        unique case (r_phase)
            lz11_pkg::PH_EXT1: begin
                tdone = r_t1[7:4] > 4'd1;
                tlen  = {13'd0, r_t1[7:4]} + 17'd1;
                tdist = {1'b0, r_t1[3:0], i_byte} + 13'd1;
            end
            lz11_pkg::PH_EXT2: begin
                tdone = r_t1[7:4] == 4'd0;
                tlen  = {9'd0, r_t1[3:0], r_t2[7:4]} + lz11_pkg::MidBias;
                tdist = {1'b0, r_t2[3:0], i_byte} + 13'd1;
            end
            lz11_pkg::PH_EXT3: begin
                tdone = 1'b1;
                tlen  = {1'b0, r_t1[3:0], r_t2, r_t3[7:4]} + lz11_pkg::LongBias;
                tdist = {1'b0, r_t3[3:0], i_byte} + 13'd1;
            end
            default: ;
        endcase
    end

    // Next state and command
    always_comb begin
        n_phase = r_phase; n_flag = r_flag; n_fpos = r_fpos;
        n_t1 = r_t1; n_t2 = r_t2; n_t3 = r_t3;
        n_rem = r_rem; n_dist = r_dist; n_left = r_left;
        n_written = r_written; n_wp = r_wp;
        o_cmd_valid = 1'b0;
        o_cmd = '0;
        o_cmd.status = lz11_pkg::ST_BYTE;
        if (fire && i_action) begin
            if (r_phase == lz11_pkg::PH_COPY) begin
                o_cmd_valid = 1'b1;
                o_cmd.is_copy = 1'b1;
                o_cmd.addr = r_wp - r_dist[Aw-1:0];
                o_cmd.waddr = r_wp;
                o_cmd.last = left_dec == 24'd0;
                n_wp = r_wp + 1'b1;
                if (r_written != WinFull) n_written = r_written + 1'b1;
                n_left = left_dec;
                n_rem = (r_rem != 17'd0) ? r_rem - 17'd1 : r_rem;
                if (left_dec == 24'd0) begin
                    n_rem = '0;
                    n_phase = lz11_pkg::PH_HDR0;
                end else if (n_rem == 17'd0) begin
                    n_flag = {r_flag[6:0], 1'b0};
                    n_fpos = r_fpos + 4'd1;
                    n_phase = (n_fpos >= 4'd8) ? lz11_pkg::PH_FLAG : lz11_pkg::PH_TOKEN;
                end
            end
        end else if (fire) begin
            unique case (r_phase)
                lz11_pkg::PH_HDR0: begin
                    if (i_byte != lz11_pkg::TypeByte) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.is_err = 1'b1;
                        o_cmd.status = lz11_pkg::ST_BAD_TYPE;
                        n_rem = '0;
                    end else begin
                        n_left = '0;
                        n_written = '0;
                        n_phase = lz11_pkg::PH_HDR1;
                    end
                end
                lz11_pkg::PH_HDR1: begin
                    n_left = {16'd0, i_byte};
                    n_phase = lz11_pkg::PH_HDR2;
                end
                lz11_pkg::PH_HDR2: begin
                    n_left[15:8] = i_byte;
                    n_phase = lz11_pkg::PH_HDR3;
                end
                lz11_pkg::PH_HDR3: begin
                    n_left[23:16] = i_byte;
                    n_phase = (n_left == 24'd0) ? lz11_pkg::PH_HDR0 : lz11_pkg::PH_FLAG;
                end
                lz11_pkg::PH_FLAG: begin
                    n_flag = i_byte;
                    n_fpos = '0;
                    n_phase = lz11_pkg::PH_TOKEN;
                end
                lz11_pkg::PH_TOKEN: begin
                    if (!r_flag[7]) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.is_lit = 1'b1;
                        o_cmd.data = i_byte;
                        o_cmd.waddr = r_wp;
                        o_cmd.last = left_dec == 24'd0;
                        n_wp = r_wp + 1'b1;
                        if (r_written != WinFull) n_written = r_written + 1'b1;
                        n_left = left_dec;
                        n_flag = {r_flag[6:0], 1'b0};
                        n_fpos = r_fpos + 4'd1;
                        if (left_dec == 24'd0) n_phase = lz11_pkg::PH_HDR0;
                        else if (n_fpos >= 4'd8) n_phase = lz11_pkg::PH_FLAG;
                        else n_phase = lz11_pkg::PH_TOKEN;
                    end else begin
                        n_t1 = i_byte; n_t2 = '0; n_t3 = '0;
                        n_phase = lz11_pkg::PH_EXT1;
                    end
                end
                lz11_pkg::PH_EXT1, lz11_pkg::PH_EXT2, lz11_pkg::PH_EXT3: begin
                    if (r_phase == lz11_pkg::PH_EXT1) n_t2 = i_byte;
                    if (r_phase == lz11_pkg::PH_EXT2) n_t3 = i_byte;
                    if (!tdone) begin
                        n_phase = (r_phase == lz11_pkg::PH_EXT1) ? lz11_pkg::PH_EXT2
                                                                 : lz11_pkg::PH_EXT3;
                    end else if (tdist > r_written) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.is_err = 1'b1;
                        o_cmd.status = lz11_pkg::ST_TOO_FAR;
                        n_phase = lz11_pkg::PH_HDR0;
                        n_rem = '0;
                    end else begin
                        n_rem = tlen;
                        n_dist = tdist;
                        n_phase = lz11_pkg::PH_COPY;
                    end
                end
                lz11_pkg::PH_COPY: begin
                    o_cmd_valid = 1'b1;
                    o_cmd.is_err = 1'b1;
                    o_cmd.status = lz11_pkg::ST_REFUSED;
                    n_phase = lz11_pkg::PH_HDR0;
                    n_rem = '0;
                end
                default: n_phase = lz11_pkg::PH_HDR0;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lz11_pkg::PH_HDR0;
            r_flag <= '0; r_fpos <= '0;
            r_t1 <= '0; r_t2 <= '0; r_t3 <= '0;
            r_rem <= '0; r_dist <= '0; r_left <= '0;
            r_written <= '0; r_wp <= '0;
        end else begin
            r_phase <= n_phase;
            r_flag <= n_flag; r_fpos <= n_fpos;
            r_t1 <= n_t1; r_t2 <= n_t2; r_t3 <= n_t3;
            r_rem <= n_rem; r_dist <= n_dist; r_left <= n_left;
            r_written <= n_written; r_wp <= n_wp;
        end
    end
endmodule

// ===== design/lz11_back.sv =====
// History access: writes literals and copies, reads copy bytes, output skid.
module lz11_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  lz11_pkg::t_cmd  i_cmd,
    output logic            o_cmd_ready,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_last,
    output logic [1:0]      o_status,
    input  logic            i_ready
);
    // Stage 1: RAM read in flight; stage 2: output queue of two words
    logic           r_s1_v;
    lz11_pkg::t_cmd r_s1;
    logic [7:0]     rdata, s1_byte;
    logic [10:0]    s1_word;
    logic           r_byp;
    logic [7:0]     r_byp_data;
    logic           accept, adv, push, pop;
    logic           ram_we, ram_re;
    logic [10:0]    r_q0, r_q1, n_q0, n_q1;
    logic [1:0]     r_cnt;

    // Stage 1 advances when the queue has room for it
    assign pop    = (r_cnt != 2'd0) && i_ready;
    assign adv    = !r_s1_v || (r_cnt != 2'd2) || pop;
    assign push   = r_s1_v && adv;
    assign accept = i_cmd_valid && adv;
    assign o_cmd_ready = adv;

    // Each byte lands in history as its word leaves stage 1
    assign ram_we = push && (r_s1.is_lit || r_s1.is_copy);
    // Read only on a new copy so a stalled copy keeps its data
    assign ram_re = accept && i_cmd.is_copy;

    lz11_ram #(.WIDTH(8), .DEPTH(lz11_pkg::WindowDepth)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1.waddr),
        .i_wdata (s1_byte),
        .i_re    (ram_re),
        .i_raddr (i_cmd.addr),
        .o_rdata (rdata)
    );

    // Bypass: a copy that reads the byte being written in its accept cycle
    assign s1_byte = r_s1.is_copy ? (r_byp ? r_byp_data : rdata) : r_s1.data;
    assign s1_word = {s1_byte, r_s1.last, r_s1.status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (adv) r_s1_v <= i_cmd_valid;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= i_cmd;
            r_byp <= ram_we && (r_s1.waddr == i_cmd.addr);
            r_byp_data <= s1_byte;
        end
    end

    // Output queue next contents
    always_comb begin
        n_q0 = r_q0;
        n_q1 = r_q1;
        if (pop) n_q0 = r_q1;
        if (push) begin
            if (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop)) n_q0 = s1_word;
            else n_q1 = s1_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_valid  = r_cnt != 2'd0;
    assign o_byte   = r_q0[10:3];
    assign o_last   = r_q0[2];
    assign o_status = r_q0[1:0];
endmodule

// ===== design/lz11_checker.sv =====
// Port-level checks for the LZ11 decompressor, bound to the top level.
module lz11_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last,
    input logic [1:0] i_out_status
);
    // Error words carry a zero byte
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != lz11_pkg::ST_BYTE |-> i_out_byte == 8'd0)
        else $error("error word with nonzero byte");
    // Error words never flag last
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != lz11_pkg::ST_BYTE |-> !i_out_last)
        else $error("error word with last set");
    // Stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("output changed while stalled");
endmodule

bind lz11_decompressor_top lz11_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_out_last   (o_out.is_last),
    .i_out_status (o_out.status)
);

// ===== tb/lz11_tb_if.sv =====
// Result word type shared by the testbench.
`timescale 1ns / 1ps
package lz11_tb_types;
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_last;
        logic [1:0] status;
    } t_word;
endpackage

// ===== tb/tb.sv =====
// Testbench for the LZ11 decompressor: stream stimulus, self-checking predictor.
`timescale 1ns / 1ps
module tb;
    localparam int WIN = lz11_pkg::WindowDepth;
    localparam int STALL_LIMIT = 5000;
    localparam int N_WORDS = 1200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #4 i_clk = ~i_clk;

    lz11_in_if  in_ch();
    lz11_out_if out_ch();

    lz11_decompressor_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    // Predictor state
    lz11_pkg::t_phase ph;
    logic [7:0]  flags;
    logic [3:0]  fpos;
    logic [7:0]  tk0, tk1, tk2;
    logic [16:0] run_left;
    logic [12:0] run_dist;
    logic [23:0] size_left;
    logic [12:0] hist_count;
    logic [11:0] wptr;
    logic [7:0]  hist [WIN];

    lz11_tb_types::t_word expected_words[$];
    int    errors = 0;
    int    idle_cycles = 0;
    int    words_sent = 0;
    int    hold = 0;
    int    out_gap;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.compressed_byte = 8'h00;
        out_ch.ready = 1'b0;
    end

    task automatic model_reset();
        ph = lz11_pkg::PH_HDR0; flags = 0; fpos = 0; tk0 = 0; tk1 = 0; tk2 = 0;
        run_left = 0; run_dist = 0; size_left = 0; hist_count = 0; wptr = 0;
        foreach (hist[i]) hist[i] = 8'h00;
    endtask

    function automatic void push_word(logic [7:0] b, logic l, lz11_pkg::t_status s);
        lz11_tb_types::t_word w;
        w.out_byte = b; w.is_last = l; w.status = s;
        expected_words.push_back(w);
    endfunction

    function automatic void abort_stream(lz11_pkg::t_status s);
        ph = lz11_pkg::PH_HDR0;
        run_left = 0;
        push_word(8'h00, 1'b0, s);
    endfunction

    function automatic logic store_byte(logic [7:0] b);
        hist[wptr] = b;
        wptr = wptr + 1'b1;
        if (hist_count < WIN) hist_count++;
        if (size_left != 0) size_left--;
        return size_left == 0;
    endfunction

    function automatic void advance_item();
        flags = flags << 1;
        fpos++;
        if (size_left == 0) ph = lz11_pkg::PH_HDR0;
        else if (fpos >= 8) ph = lz11_pkg::PH_FLAG;
        else ph = lz11_pkg::PH_TOKEN;
    endfunction

    function automatic void start_copy(logic [16:0] len, logic [12:0] back_ofs);
        if (back_ofs > hist_count) abort_stream(lz11_pkg::ST_TOO_FAR);
        else begin
            run_left = len; run_dist = back_ofs; ph = lz11_pkg::PH_COPY;
        end
    endfunction

    // Expected results of one accepted word
    function automatic void decode_word(logic act, logic [7:0] b);
        logic [7:0] cb;
        logic lst;
        logic [11:0] src;
        if (act) begin
            if (ph != lz11_pkg::PH_COPY) return;
            src = wptr - run_dist[11:0];
            cb = hist[src];
            lst = store_byte(cb);
            if (run_left != 0) run_left--;
            if (lst) begin
                run_left = 0; ph = lz11_pkg::PH_HDR0;
            end else if (run_left == 0) begin
                advance_item();
            end
            push_word(cb, lst, lz11_pkg::ST_BYTE);
            return;
        end
        case (ph)
            lz11_pkg::PH_HDR0: begin
                if (b != lz11_pkg::TypeByte) abort_stream(lz11_pkg::ST_BAD_TYPE);
                else begin
                    size_left = 0; hist_count = 0; ph = lz11_pkg::PH_HDR1;
                end
            end
            lz11_pkg::PH_HDR1: begin size_left = {16'h0, b}; ph = lz11_pkg::PH_HDR2; end
            lz11_pkg::PH_HDR2: begin size_left[15:8] = b; ph = lz11_pkg::PH_HDR3; end
            lz11_pkg::PH_HDR3: begin
                size_left[23:16] = b;
                ph = (size_left == 0) ? lz11_pkg::PH_HDR0 : lz11_pkg::PH_FLAG;
            end
            lz11_pkg::PH_FLAG: begin flags = b; fpos = 0; ph = lz11_pkg::PH_TOKEN; end
            lz11_pkg::PH_TOKEN: begin
                if (!flags[7]) begin
                    lst = store_byte(b);
                    advance_item();
                    push_word(b, lst, lz11_pkg::ST_BYTE);
                end else begin
                    tk0 = b; tk1 = 0; tk2 = 0; ph = lz11_pkg::PH_EXT1;
                end
            end
            lz11_pkg::PH_EXT1: begin
                tk1 = b;
                if (tk0[7:4] <= 1) ph = lz11_pkg::PH_EXT2;
                else start_copy(17'(tk0[7:4]) + 17'd1, {1'b0, tk0[3:0], tk1} + 13'd1);
            end
            lz11_pkg::PH_EXT2: begin
                tk2 = b;
                if (tk0[7:4] == 1) ph = lz11_pkg::PH_EXT3;
                else start_copy({9'h0, tk0[3:0], tk1[7:4]} + lz11_pkg::MidBias,
                                {1'b0, tk1[3:0], tk2} + 13'd1);
            end
            lz11_pkg::PH_EXT3:
                start_copy({1'b0, tk0[3:0], tk1, tk2[7:4]} + lz11_pkg::LongBias,
                           {1'b0, tk2[3:0], b} + 13'd1);
            lz11_pkg::PH_COPY: abort_stream(lz11_pkg::ST_REFUSED);
            default: ph = lz11_pkg::PH_HDR0;
        endcase
    endfunction

    // Send one word with a random lead-in gap
    task automatic send_word(logic act, logic [7:0] b);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.compressed_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
        decode_word(act, b);
    endtask

    // Drain every pending copy byte
    task automatic drain_copy();
        while (ph == lz11_pkg::PH_COPY) send_word(1'b1, 8'($urandom));
    endtask

    task automatic send_header(int unsigned sz);
        send_word(1'b0, lz11_pkg::TypeByte);
        send_word(1'b0, sz[7:0]);
        send_word(1'b0, sz[15:8]);
        send_word(1'b0, sz[23:16]);
    endtask

    // One stream: literals first, then random tokens, some too far back or cut by a refused byte
    task automatic send_stream(int unsigned sz, int unsigned items);
        logic [7:0] f;
        int n, ofs, len, kind;
        send_header(sz);
        n = 0;
        while (ph != lz11_pkg::PH_HDR0 && n < items) begin
            f = (hist_count < 2) ? 8'h00 : 8'($urandom);
            send_word(1'b0, f);
            for (int k = 0; k < 8 && ph != lz11_pkg::PH_HDR0 && n < items; k++) begin
                n++;
                if (!f[7-k]) send_word(1'b0, 8'($urandom));
                else begin
                    ofs = $urandom_range(1, hist_count);
                    if ($urandom_range(0, 19) == 0) ofs = hist_count + 1;
                    ofs = ofs - 1;
                    kind = $urandom_range(0, 9);
                    if (kind == 0) begin
                        len = $urandom_range(0, 15);
                        send_word(1'b0, 8'h00);
                        send_word(1'b0, {len[3:0], 4'(ofs >> 8)});
                        send_word(1'b0, ofs[7:0]);
                    end else if (kind == 1) begin
                        len = $urandom_range(0, 40);
                        send_word(1'b0, {4'h1, 4'h0});
                        send_word(1'b0, len[11:4]);
                        send_word(1'b0, {len[3:0], 4'(ofs >> 8)});
                        send_word(1'b0, ofs[7:0]);
                    end else begin
                        send_word(1'b0, {4'($urandom_range(2, 15)), 4'(ofs >> 8)});
                        send_word(1'b0, ofs[7:0]);
                    end
                    if ($urandom_range(0, 49) == 0 && ph == lz11_pkg::PH_COPY)
                        send_word(1'b0, 8'($urandom));
                    drain_copy();
                end
            end
        end
        // A stream cut short may still hold a copy
        drain_copy();
    endtask

    task automatic test_reset();
        model_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_word(1'b1, 8'hFF);                  // copy request outside copy
        send_word(1'b0, 8'h00);                  // bad type byte
        send_word(1'b0, 8'hFF);
        send_header(0);                          // zero size
        send_header(3);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'hA5);                  // last literal
        send_header(40);
        send_word(1'b0, 8'h70);                  // lit, then tokens
        send_word(1'b0, 8'h5A);
        send_word(1'b0, 8'h20);                  // short, dist 1, len 3
        send_word(1'b0, 8'h00);
        drain_copy();
        send_word(1'b0, 8'hF0);                  // len 16, dist 1
        send_word(1'b0, 8'h00);
        drain_copy();
        send_word(1'b0, 8'hFF);                  // distance too far
        send_word(1'b0, 8'hFF);
    endtask

    task automatic test_overrun();
        send_header(5);                          // copy cut at declared size
        send_word(1'b0, 8'h40);
        send_word(1'b0, 8'h3C);
        send_word(1'b0, 8'h00);                  // mid token, len 17
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h00);
        drain_copy();
        send_header(300);                        // refused byte during copy
        send_word(1'b0, 8'h40);
        send_word(1'b0, 8'h11);
        send_word(1'b0, 8'h10);                  // long token
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'hF0);
        send_word(1'b0, 8'h00);
        send_word(1'b1, 8'h00);
        send_word(1'b0, 8'h77);
    endtask

    task automatic test_random();
        logic [7:0] b;
        while (words_sent < N_WORDS) begin
            if ($urandom_range(0, 9) == 0) begin
                // Stray word while idle: never a type byte
                b = 8'($urandom);
                if (b == lz11_pkg::TypeByte) b = 8'h00;
                send_word(1'($urandom_range(0, 1)), b);
            end else begin
                send_stream($urandom_range(1, 80), $urandom_range(1, 40));
            end
            // Run a truncated stream out with zero bytes
            while (ph != lz11_pkg::PH_HDR0) begin
                if (ph == lz11_pkg::PH_COPY) drain_copy();
                else send_word(1'b0, 8'h00);
            end
        end
    endtask

    // Result checker with random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            lz11_tb_types::t_word w;
            if (expected_words.size() == 0) begin
                $error("unexpected word: out_byte %0h", out_ch.out_byte);
                errors++;
            end else begin
                w = expected_words.pop_front();
                if (out_ch.out_byte !== w.out_byte) begin
                    $error("out_byte exp %0h got %0h", w.out_byte, out_ch.out_byte);
                    errors++;
                end
                if (out_ch.is_last !== w.is_last) begin
                    $error("is_last exp %0b got %0b", w.is_last, out_ch.is_last);
                    errors++;
                end
                if (out_ch.status !== w.status) begin
                    $error("status exp %0d got %0d", w.status, out_ch.status);
                    errors++;
                end
            end
            out_gap = $urandom_range(0, 4);
            out_ch.ready <= (out_gap == 0);
            hold <= out_gap;
        end else if (hold > 1) begin
            hold <= hold - 1;
        end else begin
            hold <= 0;
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog on accept-free cycles
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        test_reset();
        test_directed();
        test_overrun();
        test_random();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
